/* hw/rtl/spe_pkg.sv */
// shared constants, codes and types of the starfield projection engine
package spe_pkg;

    localparam int STAR_COUNT  = 512;
    localparam int DEPTH_MAX   = 32;
    localparam int DEPTH_FULL  = DEPTH_MAX * 256;

    localparam int STAR_ADDR_W = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;
    localparam int Z_W         = $clog2(DEPTH_FULL + 1);
    localparam int STAR_IDX_W  = 9;
    localparam int COORD_W     = 6;
    localparam int RDEPTH_W    = 6;
    localparam int SAT_W       = 7;
    localparam int STEP_W      = 8;
    localparam int DIM_W       = 10;
    localparam int ORIGIN_W    = DIM_W - 1;
    localparam int DOT_W       = 3;
    localparam int SHADE_W     = 8;
    localparam int PROJ_SHIFT  = 15;
    localparam int PROD_W      = ORIGIN_W + Z_W;
    localparam int MAG_W       = (PROD_W > COORD_W + PROJ_SHIFT) ? PROD_W
                                                                 : COORD_W + PROJ_SHIFT;
    localparam int NUM_W       = MAG_W + 1;

    localparam int OUT_DEPTH   = 32;
    localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
    localparam int USED_W      = $clog2(OUT_DEPTH + 1);

    localparam logic CMD_INIT  = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH_STEP    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd2;

    localparam logic [STEP_W-1:0] DEPTH_STEP_RST    = 8'd49;
    localparam logic [DIM_W-1:0]  SCREEN_WIDTH_RST  = 10'd240;
    localparam logic [DIM_W-1:0]  SCREEN_HEIGHT_RST = 10'd320;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [Z_W-1:0]            z;
    } t_star;

    typedef struct packed {
        logic                      valid;
        logic                      proj;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [Z_W-1:0]            z;
    } t_star_upd;

    typedef struct packed {
        logic               visible;
        logic [DIM_W-1:0]   screen_x;
        logic [DIM_W-1:0]   screen_y;
        logic [DOT_W-1:0]   dot_size;
        logic [SHADE_W-1:0] grey_shade;
    } t_pixel;

endpackage

/* hw/rtl/spe_in_if.sv */
// input channel carrying star commands
interface spe_in_if import spe_pkg::*; ();
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [STAR_IDX_W-1:0]        star_index;
    logic signed [COORD_W-1:0]    rand_x;
    logic signed [COORD_W-1:0]    rand_y;
    logic [RDEPTH_W-1:0]          rand_depth;

    modport source (
        output valid, command, star_index, rand_x, rand_y, rand_depth,
        input  ready
    );
    modport sink (
        input  valid, command, star_index, rand_x, rand_y, rand_depth,
        output ready
    );
endinterface

/* hw/rtl/spe_out_if.sv */
// output channel carrying projected pixels
interface spe_out_if import spe_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               visible;
    logic [DIM_W-1:0]   screen_x;
    logic [DIM_W-1:0]   screen_y;
    logic [DOT_W-1:0]   dot_size;
    logic [SHADE_W-1:0] grey_shade;

    modport source (
        output valid, visible, screen_x, screen_y, dot_size, grey_shade,
        input  ready
    );
    modport sink (
        input  valid, visible, screen_x, screen_y, dot_size, grey_shade,
        output ready
    );
endinterface

/* hw/rtl/spe_star_store.sv */
// star table with read-modify-write update and write forwarding
module spe_star_store import spe_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_acc,
    input  logic                      i_command,
    input  logic [STAR_IDX_W-1:0]     i_star_index,
    input  logic signed [COORD_W-1:0] i_rand_x,
    input  logic signed [COORD_W-1:0] i_rand_y,
    input  logic [RDEPTH_W-1:0]       i_rand_depth,
    input  logic [STEP_W-1:0]         i_depth_step,
    output t_star_upd                 o_upd
);

    t_star                     r_mem [STAR_COUNT];
    t_star                     r_rd_data;

    logic                      r_s1_vld;
    logic                      r_s1_cmd;
    logic                      r_s1_inr;
    logic [STAR_ADDR_W-1:0]    r_s1_addr;
    logic signed [COORD_W-1:0] r_s1_rx;
    logic signed [COORD_W-1:0] r_s1_ry;
    logic [RDEPTH_W-1:0]       r_s1_rd;

    logic                      r_fw_vld;
    logic [STAR_ADDR_W-1:0]    r_fw_addr;
    t_star                     r_fw_data;

    t_star_upd                 r_upd;

    logic [STAR_ADDR_W-1:0]    addr_in;
    t_star                     cur;
    t_star                     n_star;
    logic [SAT_W-1:0]          rd_sat;
    logic [Z_W:0]              z_dec;
    logic                      respawn;
    logic                      wr_en;

    assign addr_in = STAR_ADDR_W'(i_star_index);
    assign wr_en   = r_s1_vld && r_s1_inr;

    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_rd_data <= r_mem[addr_in];
        end
        if (wr_en) begin
            r_mem[r_s1_addr] <= n_star;
        end
    end

    // latest write bypasses the read that raced it
    always_comb begin
        cur = r_rd_data;
        if (r_fw_vld && (r_fw_addr == r_s1_addr)) begin
            cur = r_fw_data;
        end
    end

    always_comb begin
        rd_sat  = (int'(r_s1_rd) > DEPTH_MAX) ? SAT_W'(DEPTH_MAX) : SAT_W'(r_s1_rd);
        z_dec   = {1'b0, cur.z} - (Z_W + 1)'(i_depth_step);
        respawn = z_dec[Z_W] || (z_dec == '0);
        case (r_s1_cmd)
            CMD_INIT: begin
                n_star.x = r_s1_rx;
                n_star.y = r_s1_ry;
                n_star.z = Z_W'(rd_sat) << 8;
            end
            CMD_STEP: begin
                if (respawn) begin
                    n_star.x = r_s1_rx;
                    n_star.y = r_s1_ry;
                    n_star.z = Z_W'(DEPTH_FULL);
                end else begin
                    n_star.x = cur.x;
                    n_star.y = cur.y;
                    n_star.z = z_dec[Z_W-1:0];
                end
            end
            default: begin
                n_star = cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_s1_cmd  <= i_command;
        r_s1_inr  <= int'(i_star_index) < STAR_COUNT;
        r_s1_addr <= addr_in;
        r_s1_rx   <= i_rand_x;
        r_s1_ry   <= i_rand_y;
        r_s1_rd   <= i_rand_depth;
        if (wr_en) begin
            r_fw_addr <= r_s1_addr;
            r_fw_data <= n_star;
        end
        r_upd.proj <= r_s1_inr && (r_s1_cmd == CMD_STEP);
        r_upd.x    <= n_star.x;
        r_upd.y    <= n_star.y;
        r_upd.z    <= n_star.z;
        if (!i_rst_n) begin
            r_upd.valid <= 1'b0;
        end else begin
            r_upd.valid <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld    <= 1'b0;
            r_fw_vld    <= 1'b0;
        end else begin
            r_s1_vld    <= i_acc;
            if (wr_en) begin
                r_fw_vld <= 1'b1;
            end
        end
    end

    assign o_upd = r_upd;

endmodule

/* hw/rtl/spe_divider.sv */
// pipelined restoring divider, one quotient bit per stage
module spe_divider import spe_pkg::*; (
    input  logic             i_clk,
    input  logic [MAG_W-1:0] i_dividend,
    input  logic [Z_W-1:0]   i_divisor,
    output logic [MAG_W-1:0] o_quotient
);

    logic [Z_W-1:0]   r_rem [MAG_W];
    logic [MAG_W-1:0] r_dq  [MAG_W];
    logic [Z_W-1:0]   r_dvs [MAG_W];

    for (genvar k = 0; k < MAG_W; k++) begin : g_stage
        logic [Z_W-1:0]   rem_in;
        logic [MAG_W-1:0] dq_in;
        logic [Z_W-1:0]   dvs_in;
        logic [Z_W:0]     trial;
        logic [Z_W:0]     diff;
        logic             take;

        if (k == 0) begin : g_first
            assign rem_in = '0;
            assign dq_in  = i_dividend;
            assign dvs_in = i_divisor;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dq_in  = r_dq[k-1];
            assign dvs_in = r_dvs[k-1];
        end

        assign trial = {rem_in, dq_in[MAG_W-1]};
        assign diff  = trial - {1'b0, dvs_in};
        assign take  = !diff[Z_W];

        always_ff @(posedge i_clk) begin
            r_rem[k] <= take ? diff[Z_W-1:0] : trial[Z_W-1:0];
            r_dq[k]  <= {dq_in[MAG_W-2:0], take};
            r_dvs[k] <= dvs_in;
        end
    end

    assign o_quotient = r_dq[MAG_W-1];

endmodule

/* hw/rtl/spe_out_fifo.sv */
// result queue in front of the output channel
module spe_out_fifo import spe_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  t_pixel         i_pixel,
    spe_out_if.source      o_pixel
);

    t_pixel                r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  r_wr_ptr;
    logic [OUT_PTR_W-1:0]  r_rd_ptr;
    logic [USED_W-1:0]     r_count;
    logic [USED_W-1:0]     n_count;
    logic                  pop;
    t_pixel                head;

    assign head               = r_mem[r_rd_ptr];
    assign o_pixel.valid      = r_count != '0;
    assign o_pixel.visible    = head.visible;
    assign o_pixel.screen_x   = head.screen_x;
    assign o_pixel.screen_y   = head.screen_y;
    assign o_pixel.dot_size   = head.dot_size;
    assign o_pixel.grey_shade = head.grey_shade;

    assign pop = o_pixel.valid && o_pixel.ready;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

/* hw/rtl/starfield_projection_engine.sv */
// Starfield projection engine top level. Takes one star command per clock while
// credits remain and returns exactly one pixel item per command, in order. The
// star table sits in a single-port-write synchronous memory updated by
// read-modify-write with a one-entry write bypass, so back-to-back commands to
// the same star are safe. Each projection divides by the star depth in two
// 23-stage pipelined dividers; an item is registered at each step on its way to
// a 32-entry output queue, and credit counting keeps the input ready while
// results wait. Sustained rate is one item per cycle while the output accepts.
// Configuration registers may only be written while no item is in flight.
module starfield_projection_engine import spe_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    spe_in_if.sink               i_star,
    spe_out_if.source            o_pixel,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_wdata
);

    typedef struct packed {
        logic                      vld;
        logic                      proj;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [Z_W-1:0]            z;
        logic [PROD_W-1:0]         prod_x;
        logic [PROD_W-1:0]         prod_y;
        logic [DOT_W-1:0]          dot;
        logic [SHADE_W-1:0]        grey;
    } t_s3;

    typedef struct packed {
        logic                      vld;
        logic                      proj;
        logic                      neg_x;
        logic                      neg_y;
        logic [MAG_W-1:0]          mag_x;
        logic [MAG_W-1:0]          mag_y;
        logic [Z_W-1:0]            z;
        logic [DOT_W-1:0]          dot;
        logic [SHADE_W-1:0]        grey;
    } t_s4;

    typedef struct packed {
        logic               proj;
        logic               neg_x;
        logic               neg_y;
        logic [DOT_W-1:0]   dot;
        logic [SHADE_W-1:0] grey;
    } t_side;

    logic [STEP_W-1:0] r_depth_step;
    logic [DIM_W-1:0]  r_screen_width;
    logic [DIM_W-1:0]  r_screen_height;

    logic              acc;
    logic              pop;
    logic [USED_W-1:0] r_used;

    t_star_upd         upd;
    t_s3               r_s3;
    t_s4               r_s4;
    t_side             r_side [MAG_W];
    logic [MAG_W-1:0]  r_side_vld;

    logic [Z_W-1:0]    near;
    logic [NUM_W-1:0]  sum_x;
    logic [NUM_W-1:0]  sum_y;
    logic [NUM_W-1:0]  abs_x;
    logic [NUM_W-1:0]  abs_y;
    logic [MAG_W-1:0]  quo_x;
    logic [MAG_W-1:0]  quo_y;
    logic              vis_x;
    logic              vis_y;
    t_pixel            px;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_step    <= DEPTH_STEP_RST;
            r_screen_width  <= SCREEN_WIDTH_RST;
            r_screen_height <= SCREEN_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEPTH_STEP:    r_depth_step    <= i_cfg_wdata[STEP_W-1:0];
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_wdata;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // credits for items in flight plus queued
    assign i_star.ready = i_rst_n && (r_used != USED_W'(OUT_DEPTH));
    assign acc          = i_star.valid && i_star.ready;
    assign pop          = o_pixel.valid && o_pixel.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (acc && !pop) begin
            r_used <= r_used + 1'b1;
        end else if (!acc && pop) begin
            r_used <= r_used - 1'b1;
        end
    end

    spe_star_store u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_command    (i_star.command),
        .i_star_index (i_star.star_index),
        .i_rand_x     (i_star.rand_x),
        .i_rand_y     (i_star.rand_y),
        .i_rand_depth (i_star.rand_depth),
        .i_depth_step (r_depth_step),
        .o_upd        (upd)
    );

    // origin times depth, size and shade
    assign near = Z_W'(DEPTH_FULL) - upd.z;

    always_ff @(posedge i_clk) begin
        r_s3.proj   <= upd.proj;
        r_s3.x      <= upd.x;
        r_s3.y      <= upd.y;
        r_s3.z      <= upd.z;
        r_s3.prod_x <= PROD_W'(r_screen_width[DIM_W-1:1]) * PROD_W'(upd.z);
        r_s3.prod_y <= PROD_W'(r_screen_height[DIM_W-1:1]) * PROD_W'(upd.z);
        r_s3.dot    <= DOT_W'((32'(near) * 5) / DEPTH_FULL);
        r_s3.grey   <= SHADE_W'((32'(near) * 255) / DEPTH_FULL);
        if (!i_rst_n) begin
            r_s3.vld <= 1'b0;
        end else begin
            r_s3.vld <= upd.valid;
        end
    end

    // numerator and its magnitude
    always_comb begin
        sum_x = {{(NUM_W - COORD_W - PROJ_SHIFT){r_s3.x[COORD_W-1]}}, r_s3.x,
                 {PROJ_SHIFT{1'b0}}} + {{(NUM_W - PROD_W){1'b0}}, r_s3.prod_x};
        sum_y = {{(NUM_W - COORD_W - PROJ_SHIFT){r_s3.y[COORD_W-1]}}, r_s3.y,
                 {PROJ_SHIFT{1'b0}}} + {{(NUM_W - PROD_W){1'b0}}, r_s3.prod_y};
        abs_x = sum_x[NUM_W-1] ? (~sum_x + 1'b1) : sum_x;
        abs_y = sum_y[NUM_W-1] ? (~sum_y + 1'b1) : sum_y;
    end

    always_ff @(posedge i_clk) begin
        r_s4.proj  <= r_s3.proj;
        r_s4.neg_x <= sum_x[NUM_W-1];
        r_s4.neg_y <= sum_y[NUM_W-1];
        r_s4.mag_x <= abs_x[MAG_W-1:0];
        r_s4.mag_y <= abs_y[MAG_W-1:0];
        r_s4.z     <= r_s3.z;
        r_s4.dot   <= r_s3.dot;
        r_s4.grey  <= r_s3.grey;
        if (!i_rst_n) begin
            r_s4.vld <= 1'b0;
        end else begin
            r_s4.vld <= r_s3.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_vld <= '0;
        end else begin
            r_side_vld <= {r_side_vld[MAG_W-2:0], r_s4.vld};
        end
    end

    spe_divider u_div_x (
        .i_clk      (i_clk),
        .i_dividend (r_s4.mag_x),
        .i_divisor  (r_s4.z),
        .o_quotient (quo_x)
    );

    spe_divider u_div_y (
        .i_clk      (i_clk),
        .i_dividend (r_s4.mag_y),
        .i_divisor  (r_s4.z),
        .o_quotient (quo_y)
    );

    // side data alongside the dividers
    always_ff @(posedge i_clk) begin
        r_side[0].proj  <= r_s4.proj;
        r_side[0].neg_x <= r_s4.neg_x;
        r_side[0].neg_y <= r_s4.neg_y;
        r_side[0].dot   <= r_s4.dot;
        r_side[0].grey  <= r_s4.grey;
        for (int k = 1; k < MAG_W; k++) begin
            r_side[k] <= r_side[k-1];
        end
    end

    // on-screen test and blanking
    always_comb begin
        vis_x = (!r_side[MAG_W-1].neg_x || (quo_x == '0)) &&
                (quo_x < MAG_W'(r_screen_width));
        vis_y = (!r_side[MAG_W-1].neg_y || (quo_y == '0)) &&
                (quo_y < MAG_W'(r_screen_height));
        px    = '0;
        if (r_side[MAG_W-1].proj && vis_x && vis_y) begin
            px.visible    = 1'b1;
            px.screen_x   = quo_x[DIM_W-1:0];
            px.screen_y   = quo_y[DIM_W-1:0];
            px.dot_size   = r_side[MAG_W-1].dot;
            px.grey_shade = r_side[MAG_W-1].grey;
        end
    end

    spe_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_side_vld[MAG_W-1]),
        .i_pixel (px),
        .o_pixel (o_pixel)
    );

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= USED_W'(OUT_DEPTH))
        else $error("credit count above queue depth");

    a_out_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pixel.valid |-> (r_used != '0))
        else $error("item queued without credit");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4.vld && r_s4.proj) |-> (r_s4.z != '0))
        else $error("projection with zero depth");

    a_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel.valid && !o_pixel.visible) |->
            ((o_pixel.screen_x == '0) && (o_pixel.screen_y == '0) &&
             (o_pixel.dot_size == '0) && (o_pixel.grey_shade == '0)))
        else $error("hidden item with nonzero fields");

endmodule

/* sim/testbench.sv */
// self-checking testbench for the starfield projection engine
`timescale 1ns / 100ps

module testbench import spe_pkg::*; ();

    localparam int PHASES         = 5;
    localparam int PHASE_ITEMS    = 340;
    localparam int POOL_SIZE      = 24;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int HOLD_AT_ITEM   = 60;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SCRIPT_ROWS    = 25;

    localparam t_pixel BLANK_PIXEL = '0;

    typedef struct {
        logic                      command;
        logic [STAR_IDX_W-1:0]     star_index;
        logic signed [COORD_W-1:0] rand_x;
        logic signed [COORD_W-1:0] rand_y;
        logic [RDEPTH_W-1:0]       rand_depth;
    } t_star_cmd;

    typedef struct {
        logic   command;
        int     star_index;
        int     rand_x;
        int     rand_y;
        int     rand_depth;
        bit     known;
        t_pixel px;
    } t_script_row;

    // init rows carry their all-zero result, step rows go through the predictor
    t_script_row star_script [SCRIPT_ROWS] = '{
        '{CMD_INIT,   0,   0,   0, 32, 1'b1, BLANK_PIXEL},
        '{CMD_STEP,   0,   0,   0,  0, 1'b0, BLANK_PIXEL},
        '{CMD_INIT, 511, -32,  31, 63, 1'b1, BLANK_PIXEL},
        '{CMD_STEP, 511,   1,   1,  0, 1'b0, BLANK_PIXEL},
        '{CMD_INIT,   1,  31, -32,  0, 1'b1, BLANK_PIXEL},
        '{CMD_STEP,   1,   5,  -5,  0, 1'b0, BLANK_PIXEL},
        '{CMD_INIT,   2,   0,   0,  1, 1'b1, BLANK_PIXEL},
        '{CMD_STEP,   2, -32,  31,  0, 1'b0, BLANK_PIXEL},
        '{CMD_STEP,   2, -32,  31,  0, 1'b0, BLANK_PIXEL},
        '{CMD_STEP,   2, -32,  31,  0, 1'b0, BLANK_PIXEL},
        '{CMD_STEP,   2, -32,  31,  0, 1'b0, BLANK_PIXEL},
        '{CMD_STEP,   2, -32,  31,  0, 1'b0, BLANK_PIXEL},
        '{CMD_STEP,   2, -32,  31,  0, 1'b0, BLANK_PIXEL},
        '{CMD_INIT,   3,  31,  31, 33, 1'b1, BLANK_PIXEL},
        '{CMD_STEP,   3,   0,   0,  0, 1'b0, BLANK_PIXEL},
        '{CMD_INIT,   4, -32, -32,  1, 1'b1, BLANK_PIXEL},
        '{CMD_STEP,   4,   0,   0,  0, 1'b0, BLANK_PIXEL},
        '{CMD_INIT, 256,  -1,   1, 16, 1'b1, BLANK_PIXEL},
        '{CMD_STEP, 256,   0,   0,  0, 1'b0, BLANK_PIXEL},
        '{CMD_INIT, 170,  10, -10,  8, 1'b1, BLANK_PIXEL},
        '{CMD_STEP, 170,   0,   0,  0, 1'b0, BLANK_PIXEL},
        '{CMD_INIT, 341, -10,  10,  4, 1'b1, BLANK_PIXEL},
        '{CMD_STEP, 341,   0,   0,  0, 1'b0, BLANK_PIXEL},
        '{CMD_STEP,   0,   0,   0,  0, 1'b0, BLANK_PIXEL},
        '{CMD_STEP, 511,   0,   0,  0, 1'b0, BLANK_PIXEL}
    };

    int phase_step   [PHASES] = '{49, 255, 1, 0, 128};
    int phase_width  [PHASES] = '{240, 1023, 2, 1, 640};
    int phase_height [PHASES] = '{320, 1023, 2, 0, 480};

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DIM_W-1:0]     i_cfg_wdata;

    spe_in_if  star_if ();
    spe_out_if pixel_if ();

    starfield_projection_engine DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_star      (star_if),
        .o_pixel     (pixel_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    int     star_x [STAR_COUNT];
    int     star_y [STAR_COUNT];
    int     star_z [STAR_COUNT];
    bit     star_loaded [STAR_COUNT];
    int     loaded_list [$];
    int     star_pool [POOL_SIZE];
    int     depth_step_now;
    int     width_now;
    int     height_now;
    t_pixel pending_pixels [$];
    int     fail_count;
    bit     traffic_gaps;
    bit     hold_request;

    // moves or loads one star and works out the pixel it produces
    function automatic t_pixel project_star(input t_star_cmd c);
        t_pixel px;
        longint col;
        longint row;
        int     near;
        int     i;
        px = BLANK_PIXEL;
        i = c.star_index;
        if (i >= STAR_COUNT) return px;
        if (c.command == CMD_INIT) begin
            star_x[i] = c.rand_x;
            star_y[i] = c.rand_y;
            star_z[i] = ((c.rand_depth > DEPTH_MAX) ? DEPTH_MAX : int'(c.rand_depth)) * 256;
            if (!star_loaded[i]) begin
                star_loaded[i] = 1'b1;
                loaded_list.push_back(i);
            end
            return px;
        end
        star_z[i] -= depth_step_now;
        if (star_z[i] <= 0) begin
            star_x[i] = c.rand_x;
            star_y[i] = c.rand_y;
            star_z[i] = DEPTH_FULL;
        end
        col = (longint'(star_x[i]) * 32768 + longint'(width_now / 2) * star_z[i]) / star_z[i];
        row = (longint'(star_y[i]) * 32768 + longint'(height_now / 2) * star_z[i]) / star_z[i];
        if (col >= 0 && col < width_now && row >= 0 && row < height_now) begin
            near = DEPTH_FULL - star_z[i];
            px.visible    = 1'b1;
            px.screen_x   = col[DIM_W-1:0];
            px.screen_y   = row[DIM_W-1:0];
            px.dot_size   = DOT_W'((near * 5) / DEPTH_FULL);
            px.grey_shade = SHADE_W'((near * 255) / DEPTH_FULL);
        end
        return px;
    endfunction

    // mostly steps on a small pool of loaded stars, with inits mixed in
    function automatic t_star_cmd pick_star_cmd();
        t_star_cmd c;
        int        slot;
        slot = star_pool[$urandom_range(0, POOL_SIZE - 1)];
        c.rand_x = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 8) - 4)
                                         : COORD_W'($urandom_range(0, 63));
        c.rand_y = $urandom_range(0, 1) ? COORD_W'($urandom_range(0, 8) - 4)
                                         : COORD_W'($urandom_range(0, 63));
        c.rand_depth = $urandom_range(0, 1) ? RDEPTH_W'($urandom_range(0, 8))
                                             : RDEPTH_W'($urandom_range(0, 63));
        if ($urandom_range(0, 99) < 20) begin
            c.command = CMD_INIT;
            if ($urandom_range(0, 99) >= 70) slot = $urandom_range(0, STAR_COUNT - 1);
        end else begin
            c.command = CMD_STEP;
            if (!star_loaded[slot] || $urandom_range(0, 99) < 15)
                slot = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
        end
        c.star_index = STAR_IDX_W'(slot);
        return c;
    endfunction

    task automatic offer_star(input t_star_cmd c, input bit known, input t_pixel fixed_px);
        t_pixel px;
        star_if.valid      <= 1'b1;
        star_if.command    <= c.command;
        star_if.star_index <= c.star_index;
        star_if.rand_x     <= c.rand_x;
        star_if.rand_y     <= c.rand_y;
        star_if.rand_depth <= c.rand_depth;
        do @(posedge i_clk); while (star_if.ready !== 1'b1);
        px = project_star(c);
        pending_pixels.push_back(known ? fixed_px : px);
    endtask

    task automatic sender_gap();
        int n;
        n = 0;
        while (traffic_gaps && $urandom_range(0, 99) < 25) n++;
        if (n > 0) begin
            star_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_pixels();
        star_if.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_settings(input int step, input int width, input int height);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_DEPTH_STEP;
        i_cfg_wdata <= DIM_W'(step[STEP_W-1:0]);
        @(posedge i_clk);
        i_cfg_index <= CFG_SCREEN_WIDTH;
        i_cfg_wdata <= DIM_W'(width);
        @(posedge i_clk);
        i_cfg_index <= CFG_SCREEN_HEIGHT;
        i_cfg_wdata <= DIM_W'(height);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        depth_step_now = step;
        width_now      = width;
        height_now     = height;
    endtask

    initial begin : stimulus
        t_star_cmd c;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_index        <= CFG_DEPTH_STEP;
        i_cfg_wdata        <= '0;
        star_if.valid      <= 1'b0;
        star_if.command    <= CMD_INIT;
        star_if.star_index <= '0;
        star_if.rand_x     <= '0;
        star_if.rand_y     <= '0;
        star_if.rand_depth <= '0;
        depth_step_now = DEPTH_STEP_RST;
        width_now      = SCREEN_WIDTH_RST;
        height_now     = SCREEN_HEIGHT_RST;
        fail_count     = 0;
        traffic_gaps   = 1'b1;
        hold_request   = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (star_script[r]) begin
            c.command    = star_script[r].command;
            c.star_index = STAR_IDX_W'(star_script[r].star_index);
            c.rand_x     = COORD_W'(star_script[r].rand_x);
            c.rand_y     = COORD_W'(star_script[r].rand_y);
            c.rand_depth = RDEPTH_W'(star_script[r].rand_depth);
            offer_star(c, star_script[r].known, star_script[r].px);
            sender_gap();
        end
        drain_pixels();

        for (int p = 0; p < PHASES; p++) begin
            write_settings(phase_step[p], phase_width[p], phase_height[p]);
            foreach (star_pool[k]) star_pool[k] = $urandom_range(0, STAR_COUNT - 1);
            traffic_gaps = (p != 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 0 && n == HOLD_AT_ITEM) hold_request = 1'b1;
                c = pick_star_cmd();
                offer_star(c, 1'b0, BLANK_PIXEL);
                sender_gap();
            end
            drain_pixels();
        end

        if (fail_count == 0 && pending_pixels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin : pixel_sink
        t_pixel got;
        t_pixel want;
        int     hold_left;
        hold_left = 0;
        pixel_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1) begin
                got = {pixel_if.visible, pixel_if.screen_x, pixel_if.screen_y,
                       pixel_if.dot_size, pixel_if.grey_shade};
                if (pending_pixels.size() == 0) begin
                    fail_count++;
                    $display("%0t: pixel item with none expected, got %p", $time, got);
                end else begin
                    want = pending_pixels.pop_front();
                    if (got.visible !== want.visible || got.screen_x !== want.screen_x ||
                        got.screen_y !== want.screen_y || got.dot_size !== want.dot_size ||
                        got.grey_shade !== want.grey_shade) begin
                        fail_count++;
                        $display({"%0t: expected vis %0d x %0d y %0d size %0d shade %0d,",
                                  " got vis %0d x %0d y %0d size %0d shade %0d"},
                                 $time, want.visible, want.screen_x, want.screen_y,
                                 want.dot_size, want.grey_shade, got.visible, got.screen_x,
                                 got.screen_y, got.dot_size, got.grey_shade);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                pixel_if.ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                pixel_if.ready <= 1'b0;
            end else begin
                pixel_if.ready <= traffic_gaps ? ($urandom_range(0, 99) >= 25) : 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((star_if.valid === 1'b1 && star_if.ready === 1'b1) ||
                (pixel_if.valid === 1'b1 && pixel_if.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("== FAIL ==");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/spe_pkg.sv
hw/rtl/spe_in_if.sv
hw/rtl/spe_out_if.sv
hw/rtl/spe_star_store.sv
hw/rtl/spe_divider.sv
hw/rtl/spe_out_fifo.sv
hw/rtl/starfield_projection_engine.sv
sim/testbench.sv
